// ===== design/cdll_pkg.sv =====
// ----------------------------------------------------------------------------
// cdll_pkg
// Shared constants and types of the circular doubly linked list engine.
// ----------------------------------------------------------------------------
package cdll_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W  = 4;
   localparam int VAL_W  = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 3;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BACK  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 4'd3;
   localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_DEL_AT    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DEL_KEY   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_READ_AT   = 4'd9;

   localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOKEY  = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BADPOS = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_ALLOC,
      S_WALK,
      S_TAIL,
      S_LINK1,
      S_LINK2,
      S_UNLINK,
      S_RESP
   } state_type;

   typedef struct packed {
      logic val;
      logic nxt;
      logic prv;
      logic fs;
   } wr_en_type;

endpackage

// ===== design/cdll_store.sv =====
// ----------------------------------------------------------------------------
// cdll_store
// Slot memories (value, next link, previous link) and the free-slot stack,
// each with one write port and a registered read port.
// ----------------------------------------------------------------------------
module cdll_store #(
   parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  logic [$clog2(CAPACITY)-1:0]   fs_rd_addr,
   input  cdll_pkg::wr_en_type           we,
   input  logic [$clog2(CAPACITY)-1:0]   val_waddr,
   input  logic [DATA_WIDTH-1:0]         val_wdata,
   input  logic [$clog2(CAPACITY)-1:0]   nxt_waddr,
   input  logic [$clog2(CAPACITY)-1:0]   nxt_wdata,
   input  logic [$clog2(CAPACITY)-1:0]   prv_waddr,
   input  logic [$clog2(CAPACITY)-1:0]   prv_wdata,
   input  logic [$clog2(CAPACITY)-1:0]   fs_waddr,
   input  logic [$clog2(CAPACITY)-1:0]   fs_wdata,
   output logic [DATA_WIDTH-1:0]         rd_val,
   output logic [$clog2(CAPACITY)-1:0]   rd_nxt,
   output logic [$clog2(CAPACITY)-1:0]   rd_prv,
   output logic [$clog2(CAPACITY)-1:0]   fs_rd_data
);
   import cdll_pkg::*;

   localparam int CW = $clog2(CAPACITY);

   logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
   logic [CW-1:0]         nxt_mem [CAPACITY];
   logic [CW-1:0]         prv_mem [CAPACITY];
   logic [CW-1:0]         fs_mem  [CAPACITY];

   always_ff @(posedge clock) begin
      if (we.val) begin
         val_mem[val_waddr] <= val_wdata;
      end
      rd_val <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.nxt) begin
         nxt_mem[nxt_waddr] <= nxt_wdata;
      end
      rd_nxt <= nxt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.prv) begin
         prv_mem[prv_waddr] <= prv_wdata;
      end
      rd_prv <= prv_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we.fs) begin
         fs_mem[fs_waddr] <= fs_wdata;
      end
      fs_rd_data <= fs_mem[fs_rd_addr];
   end

endmodule

// ===== design/cdll_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdll_ctrl
// Command sequencer: list registers, slot allocation, link walk and the
// read-modify-write of the slot memories; holds the result register.
// ----------------------------------------------------------------------------
module cdll_ctrl #(
   parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cdll_pkg::CMD_W-1:0]    req_cmd,
   input  logic signed [cdll_pkg::VAL_W-1:0] req_value,
   input  logic [cdll_pkg::POS_W-1:0]    req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cdll_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [cdll_pkg::VAL_W-1:0] rsp_result_value,
   output logic [cdll_pkg::POS_W-1:0]    rsp_found_position,
   output logic [cdll_pkg::POS_W-1:0]    rsp_element_count,
   output logic [$clog2(CAPACITY)-1:0]   rd_addr,
   output logic [$clog2(CAPACITY)-1:0]   fs_rd_addr,
   output cdll_pkg::wr_en_type           we,
   output logic [$clog2(CAPACITY)-1:0]   val_waddr,
   output logic [DATA_WIDTH-1:0]         val_wdata,
   output logic [$clog2(CAPACITY)-1:0]   nxt_waddr,
   output logic [$clog2(CAPACITY)-1:0]   nxt_wdata,
   output logic [$clog2(CAPACITY)-1:0]   prv_waddr,
   output logic [$clog2(CAPACITY)-1:0]   prv_wdata,
   output logic [$clog2(CAPACITY)-1:0]   fs_waddr,
   output logic [$clog2(CAPACITY)-1:0]   fs_wdata,
   input  logic [DATA_WIDTH-1:0]         rd_val,
   input  logic [$clog2(CAPACITY)-1:0]   rd_nxt,
   input  logic [$clog2(CAPACITY)-1:0]   rd_prv,
   input  logic [$clog2(CAPACITY)-1:0]   fs_rd_data
);
   import cdll_pkg::*;

   localparam int CW = $clog2(CAPACITY);
   localparam int NW = $clog2(CAPACITY + 1);
   localparam int IW = ((NW > POS_W) ? NW : POS_W) + 1;

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [CW-1:0]         head_ff, head_in;
   logic [NW-1:0]         count_ff, count_in;
   logic [NW-1:0]         fs_cnt_ff, fs_cnt_in;
   logic [NW-1:0]         fresh_ff, fresh_in;
   logic [CW-1:0]         t_ff, t_in;
   logic [CW-1:0]         n_ff, n_in;
   logic [CW-1:0]         s_ff, s_in;
   logic [IW-1:0]         i_ff, i_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [DATA_WIDTH-1:0] rv_ff, rv_in;
   logic [POS_W-1:0]      fpos_ff, fpos_in;

   logic [IW-1:0] i_p1, pos_x, cnt_x;
   logic          at_tail, key_hit, walk_done, full, empty, bad_read;
   logic          is_ins, is_take, is_key;
   logic [CW-1:0] new_slot;
   logic [63:0]   req_ext;
   logic [63:0]   rv_ext;

   always_comb begin
      i_p1     = i_ff + 1'b1;
      pos_x    = IW'(pos_ff);
      cnt_x    = IW'(count_ff);
      at_tail  = (rd_nxt == head_ff);
      key_hit  = (rd_val == key_ff);
      full     = (count_ff == NW'(CAPACITY));
      empty    = (count_ff == '0);
      bad_read = (pos_ff == '0) || (pos_x > cnt_x);
      is_ins   = (cmd_ff inside {CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT});
      is_take  = (cmd_ff inside {[CMD_DEL_FRONT:CMD_SEARCH], CMD_READ_AT});
      is_key   = (cmd_ff inside {CMD_DEL_KEY, CMD_SEARCH});
      new_slot = (fs_cnt_ff != '0) ? fs_rd_data : fresh_ff[CW-1:0];
      case (cmd_ff)
         CMD_INS_AT:              walk_done = !(i_p1 < pos_x) || at_tail;
         CMD_DEL_KEY, CMD_SEARCH: walk_done = key_hit || !(i_p1 < cnt_x);
         default:                 walk_done = !(i_ff < pos_x) || at_tail;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (is_ins) begin
               state_in = full ? S_RESP : S_ALLOC;
            end else if (is_take) begin
               if (empty || (cmd_ff == CMD_READ_AT && bad_read)) begin
                  state_in = S_RESP;
               end else if (cmd_ff == CMD_DEL_FRONT) begin
                  state_in = S_UNLINK;
               end else if (cmd_ff == CMD_DEL_BACK) begin
                  state_in = S_TAIL;
               end else begin
                  state_in = S_WALK;
               end
            end else begin
               state_in = S_RESP;
            end
         end
         S_ALLOC: begin
            if (empty) begin
               state_in = S_RESP;
            end else if (cmd_ff == CMD_INS_AT) begin
               state_in = S_WALK;
            end else begin
               state_in = S_LINK1;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               case (cmd_ff)
                  CMD_INS_AT:  state_in = S_LINK1;
                  CMD_DEL_AT:  state_in = (t_ff == head_ff) ? S_RESP : S_UNLINK;
                  CMD_DEL_KEY: state_in = key_hit ? S_UNLINK : S_RESP;
                  default:     state_in = S_RESP;
               endcase
            end
         end
         S_TAIL:   state_in = S_UNLINK;
         S_LINK1:  state_in = S_LINK2;
         S_LINK2:  state_in = S_RESP;
         S_UNLINK: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      fs_cnt_in = fs_cnt_ff;
      fresh_in  = fresh_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      s_in      = s_ff;
      i_in      = i_ff;
      status_in = status_ff;
      rv_in     = rv_ff;
      fpos_in   = fpos_ff;
      we        = '0;
      val_waddr = s_ff;
      val_wdata = key_ff;
      nxt_waddr = s_ff;
      nxt_wdata = n_ff;
      prv_waddr = s_ff;
      prv_wdata = t_ff;
      fs_waddr  = fs_cnt_ff[CW-1:0];
      fs_wdata  = t_ff;
      fs_rd_addr = CW'(fs_cnt_ff - 1'b1);
      req_ext   = {{32{req_value[31]}}, req_value};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = req_cmd;
               key_in = req_ext[DATA_WIDTH-1:0];
               pos_in = req_position;
            end
         end
         S_START: begin
            t_in      = head_ff;
            i_in      = is_key ? '0 : IW'(1);
            status_in = STAT_OK;
            rv_in     = '0;
            fpos_in   = '0;
            if (is_ins) begin
               if (full) begin
                  status_in = STAT_FULL;
               end
            end else if (is_take) begin
               if (empty) begin
                  status_in = STAT_EMPTY;
               end else if (cmd_ff == CMD_READ_AT && bad_read) begin
                  status_in = STAT_BADPOS;
               end
            end else if (cmd_ff == CMD_CLEAR) begin
               count_in  = '0;
               head_in   = '0;
               fs_cnt_in = '0;
               fresh_in  = '0;
            end
         end
         S_ALLOC: begin
            s_in = new_slot;
            if (fs_cnt_ff != '0) begin
               fs_cnt_in = fs_cnt_ff - 1'b1;
            end else begin
               fresh_in = fresh_ff + 1'b1;
            end
            if (empty) begin
               we.val    = 1'b1;
               we.nxt    = 1'b1;
               we.prv    = 1'b1;
               val_waddr = new_slot;
               nxt_waddr = new_slot;
               nxt_wdata = new_slot;
               prv_waddr = new_slot;
               prv_wdata = new_slot;
               head_in   = new_slot;
               count_in  = NW'(1);
            end else if (cmd_ff != CMD_INS_AT) begin
               t_in = rd_prv;
               n_in = head_ff;
            end
         end
         S_WALK: begin
            if (!walk_done) begin
               t_in = rd_nxt;
               i_in = i_p1;
            end else begin
               case (cmd_ff)
                  CMD_INS_AT: n_in = rd_nxt;
                  CMD_DEL_AT: begin
                     if (t_ff == head_ff) begin
                        status_in = STAT_BADPOS;
                     end
                  end
                  CMD_DEL_KEY: begin
                     if (!key_hit) begin
                        status_in = STAT_NOKEY;
                     end
                  end
                  CMD_SEARCH: begin
                     if (key_hit) begin
                        fpos_in = POS_W'(i_p1);
                     end else begin
                        status_in = STAT_NOKEY;
                     end
                  end
                  default: rv_in = rd_val;
               endcase
            end
         end
         S_TAIL: t_in = rd_prv;
         S_LINK1: begin
            we.val = 1'b1;
            we.nxt = 1'b1;
            we.prv = 1'b1;
         end
         S_LINK2: begin
            we.nxt    = 1'b1;
            we.prv    = 1'b1;
            nxt_waddr = t_ff;
            nxt_wdata = s_ff;
            prv_waddr = n_ff;
            prv_wdata = s_ff;
            count_in  = count_ff + 1'b1;
            if (cmd_ff == CMD_INS_FRONT) begin
               head_in = s_ff;
            end
         end
         S_UNLINK: begin
            rv_in     = rd_val;
            we.fs     = 1'b1;
            fs_cnt_in = fs_cnt_ff + 1'b1;
            if (count_ff <= NW'(1)) begin
               count_in = '0;
               head_in  = '0;
            end else begin
               we.nxt    = 1'b1;
               we.prv    = 1'b1;
               nxt_waddr = rd_prv;
               nxt_wdata = rd_nxt;
               prv_waddr = rd_nxt;
               prv_wdata = rd_prv;
               count_in  = count_ff - 1'b1;
               if (t_ff == head_ff) begin
                  head_in = rd_nxt;
               end
            end
         end
         default: begin
         end
      endcase
      rd_addr = t_in;
   end

   // handshake outputs
   always_comb begin
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         fs_cnt_ff <= '0;
         fresh_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         fs_cnt_ff <= fs_cnt_in;
         fresh_ff  <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      s_ff      <= s_in;
      i_ff      <= i_in;
      status_ff <= status_in;
      rv_ff     <= rv_in;
      fpos_ff   <= fpos_in;
   end

   assign rv_ext             = 64'($signed(rv_ff));
   assign rsp_status         = status_ff;
   assign rsp_result_value   = rv_ext[VAL_W-1:0];
   assign rsp_found_position = fpos_ff;
   assign rsp_element_count  = POS_W'(count_ff);

endmodule

// ===== design/circular_doubly_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// circular_doubly_linked_list_engine_top
// Bounded list of signed values kept as a circular doubly linked list in
// slot memories with a free-slot stack; one status result per command.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_stall  req_cmd, req_value, req_position
//   rsp      out  rsp_valid / rsp_stall  rsp_status, rsp_result_value,
//                                        rsp_found_position, rsp_element_count
//
// One command at a time. Clear, unknown commands and commands refused up front
// go straight from start to result; end inserts and deletes add allocation, tail,
// link or unlink steps; positional and key commands also walk the links, one
// per step, paced by the registered read ports of the slot memories.
// Synchronous reset empties the list; no memory clearing pass is needed.
// req_stall stays high until the result transfer completes.
// ----------------------------------------------------------------------------
module circular_doubly_linked_list_engine_top #(
   parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = cdll_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [cdll_pkg::CMD_W-1:0]        req_cmd,
   input  logic signed [cdll_pkg::VAL_W-1:0] req_value,
   input  logic [cdll_pkg::POS_W-1:0]        req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [cdll_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [cdll_pkg::VAL_W-1:0] rsp_result_value,
   output logic [cdll_pkg::POS_W-1:0]        rsp_found_position,
   output logic [cdll_pkg::POS_W-1:0]        rsp_element_count
);
   import cdll_pkg::*;

   localparam int CW = $clog2(CAPACITY);

   logic [CW-1:0]         rd_addr, fs_rd_addr;
   wr_en_type             we;
   logic [CW-1:0]         val_waddr, nxt_waddr, nxt_wdata;
   logic [CW-1:0]         prv_waddr, prv_wdata, fs_waddr, fs_wdata;
   logic [DATA_WIDTH-1:0] val_wdata, rd_val;
   logic [CW-1:0]         rd_nxt, rd_prv, fs_rd_data;

   cdll_ctrl #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_value          (req_value),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_result_value   (rsp_result_value),
      .rsp_found_position (rsp_found_position),
      .rsp_element_count  (rsp_element_count),
      .rd_addr            (rd_addr),
      .fs_rd_addr         (fs_rd_addr),
      .we                 (we),
      .val_waddr          (val_waddr),
      .val_wdata          (val_wdata),
      .nxt_waddr          (nxt_waddr),
      .nxt_wdata          (nxt_wdata),
      .prv_waddr          (prv_waddr),
      .prv_wdata          (prv_wdata),
      .fs_waddr           (fs_waddr),
      .fs_wdata           (fs_wdata),
      .rd_val             (rd_val),
      .rd_nxt             (rd_nxt),
      .rd_prv             (rd_prv),
      .fs_rd_data         (fs_rd_data)
   );

   cdll_store #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock      (clock),
      .rd_addr    (rd_addr),
      .fs_rd_addr (fs_rd_addr),
      .we         (we),
      .val_waddr  (val_waddr),
      .val_wdata  (val_wdata),
      .nxt_waddr  (nxt_waddr),
      .nxt_wdata  (nxt_wdata),
      .prv_waddr  (prv_waddr),
      .prv_wdata  (prv_wdata),
      .fs_waddr   (fs_waddr),
      .fs_wdata   (fs_wdata),
      .rd_val     (rd_val),
      .rd_nxt     (rd_nxt),
      .rd_prv     (rd_prv),
      .fs_rd_data (fs_rd_data)
   );

endmodule
